// ----- src/ready_queue_scheduler_assert.svh -----
// Assertion macros for the ready queue scheduler.
`ifndef READY_QUEUE_SCHEDULER_ASSERT_SVH
`define READY_QUEUE_SCHEDULER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RQS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ready queue scheduler check failed");

// Check cons in the cycle after ante.
`define RQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ready queue scheduler check failed");

`endif

// ----- src/rqs_pkg.sv -----
// Shared types and constants of the ready queue scheduler.
`timescale 1ns / 1ps
package rqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 3;
    localparam int MODE_W    = 2;
    localparam int CNT_OUT_W = 7;
    localparam int BIT_W     = $clog2(PRIO_W);

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SELECT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_PRIO;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_LIVE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

    // Operations broadcast to every cell of the chain.
    localparam logic [2:0] CELL_HOLD  = 3'd0;
    localparam logic [2:0] CELL_MATCH = 3'd1;
    localparam logic [2:0] CELL_LOAD  = 3'd2;
    localparam logic [2:0] CELL_SHIFT = 3'd3;
    localparam logic [2:0] CELL_INIT  = 3'd4;
    localparam logic [2:0] CELL_STEP  = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [BIT_W-1:0]  bit_sel;
        logic              any_zero;
    } t_cell_cmd;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] task_prio;
        logic              task_live;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ID_W-1:0]      chosen_id;
        logic                 chosen_valid;
        logic [CNT_OUT_W-1:0] queue_count;
    } t_rsp;

    typedef logic [MODE_W-1:0] t_mode;

endpackage

// ----- src/rqs_chan_if.sv -----
// Valid/ready channel interface carrying one payload of type T.
`timescale 1ns / 1ps
interface rqs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rqs_cell.sv -----
// One queue slot of the cell chain: task id, priority and a search flag.
`timescale 1ns / 1ps
module rqs_cell (
    input  logic                       i_clk,
    input  rqs_pkg::t_cell_cmd         i_cmd,
    input  logic                       i_used,
    input  logic                       i_tail,
    input  logic                       i_shift_en,
    input  logic [rqs_pkg::ID_W-1:0]   i_next_id,
    input  logic [rqs_pkg::PRIO_W-1:0] i_next_prio,
    output logic [rqs_pkg::ID_W-1:0]   o_id,
    output logic [rqs_pkg::PRIO_W-1:0] o_prio,
    output logic                       o_flag,
    output logic                       o_zero
);

    logic [rqs_pkg::ID_W-1:0]   r_id;
    logic [rqs_pkg::PRIO_W-1:0] r_prio;
    logic                       r_flag;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rqs_pkg::CELL_MATCH: begin
                r_flag <= i_used && (r_id == i_cmd.id);
            end
            rqs_pkg::CELL_LOAD: begin
                if (i_tail) begin
                    r_id   <= i_cmd.id;
                    r_prio <= i_cmd.prio;
                end
            end
            rqs_pkg::CELL_SHIFT: begin
                // take the upper neighbor's entry to close the gap
                if (i_shift_en) begin
                    r_id   <= i_next_id;
                    r_prio <= i_next_prio;
                end
            end
            rqs_pkg::CELL_INIT: begin
                r_flag <= i_used;
            end
            rqs_pkg::CELL_STEP: begin
                // drop out when some candidate has a zero where this one has a one
                r_flag <= r_flag && !(i_cmd.any_zero && r_prio[i_cmd.bit_sel]);
            end
            default: begin
            end
        endcase
    end

    assign o_id   = r_id;
    assign o_prio = r_prio;
    assign o_flag = r_flag;
    assign o_zero = r_flag && !r_prio[i_cmd.bit_sel];

endmodule

// ----- src/rqs_rr_mod.sv -----
// Restoring remainder unit for the round robin index, one bit per cycle.
`timescale 1ns / 1ps
module rqs_rr_mod #(
    parameter int NUM_W = 7,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;

    assign w_trial = {r_rem, r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // shift in the next dividend bit, subtract when it fits
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                end else begin
                    r_rem <= w_trial[DEN_W-1:0];
                end
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- src/ready_queue_scheduler.sv -----
// Top level of the ready queue scheduler: sequencer, cell chain and result register.
`timescale 1ns / 1ps
// Ready queue of up to QUEUE_DEPTH task ids, each kept with the priority given
// when it was added. Each request transaction on i_req yields exactly one result
// transaction on o_rsp. Add appends at the tail unless the id is already queued,
// the task is not live or the queue is full (checked in that order); remove
// deletes an id and moves the later entries down one slot; select picks an id
// without changing the queue, by the mode held in the configuration register
// (fifo head, round robin at (last index + 1) mod count, or the first entry with
// the lowest priority value; mode 3 acts as priority). The queue is a chain of
// slot cells that all see the same broadcast command: they compare ids in
// parallel and shift toward the head all at once. One request is worked on at
// a time. On the way to the result register, add and remove pass through a
// parallel compare, a first-match pick and apply; fifo select, unused request
// codes and a select on an empty queue go straight to apply; round robin waits
// for the bit-serial remainder unit, and priority runs the bit-serial minimum
// search that clears one priority bit, MSB first, per cycle across all cells,
// then the first-match pick. The next request is taken as soon as the block is
// back in idle, even while a result still waits in the output register.
// Configuration writes complete at once and are meant for idle periods only.
// Slot contents have no reset.
module ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rqs_chan_if.sink   i_req,
    rqs_chan_if.source o_rsp,
    rqs_chan_if.sink   i_cfg
);

`include "ready_queue_scheduler_assert.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    // Sequencer and queue state.
    logic [2:0]                  r_state;
    rqs_pkg::t_req               r_req;
    rqs_pkg::t_mode              r_mode;
    logic [CW-1:0]               r_count;
    logic [AW-1:0]               r_rr;
    logic [QUEUE_DEPTH-1:0]      r_sel;
    logic                        r_hit;
    logic [rqs_pkg::BIT_W-1:0]   r_bit;
    logic                        r_out_valid;
    rqs_pkg::t_rsp               r_rsp;

    logic [CW-1:0]               n_count;

    // Chain signals.
    rqs_pkg::t_cell_cmd          w_cmd;
    logic [rqs_pkg::ID_W-1:0]    w_id   [QUEUE_DEPTH];
    logic [rqs_pkg::PRIO_W-1:0]  w_prio [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      w_flag;
    logic [QUEUE_DEPTH-1:0]      w_zero;
    logic [QUEUE_DEPTH-1:0]      w_used;
    logic [QUEUE_DEPTH-1:0]      w_tail;
    logic [QUEUE_DEPTH-1:0]      w_rr_hot;
    logic [QUEUE_DEPTH-1:0]      w_first;
    logic [QUEUE_DEPTH-1:0]      w_shift_en;
    logic [QUEUE_DEPTH-1:0]      w_id_col [rqs_pkg::ID_W];
    logic [rqs_pkg::ID_W-1:0]    w_chosen;
    logic                        w_any;
    logic                        w_any_zero;

    // Request and result control.
    logic                        w_accept;
    logic                        w_commit;
    logic                        w_load;
    logic                        w_unload;
    logic                        w_valid;
    logic [rqs_pkg::STAT_W-1:0]  w_status;

    // Round robin remainder.
    logic                        w_mod_start;
    logic                        w_mod_done;
    logic [CW-1:0]               w_rem;
    logic [AW-1:0]               w_rem_idx;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_commit    = (r_state == S_APPLY) && (!r_out_valid || o_rsp.ready);

    // Lowest set flag as a one-hot, and every slot at or above the selected one.
    assign w_first    = w_flag & (~w_flag + QUEUE_DEPTH'(1));
    assign w_any      = |w_flag;
    assign w_shift_en = ~(r_sel - QUEUE_DEPTH'(1));
    assign w_any_zero = |w_zero;
    assign w_rem_idx  = AW'(w_rem);

    genvar gi, gb;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic [rqs_pkg::ID_W-1:0]   w_next_id;
            logic [rqs_pkg::PRIO_W-1:0] w_next_prio;

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign w_next_id   = '0;
                assign w_next_prio = '0;
            end else begin : g_mid
                assign w_next_id   = w_id[gi+1];
                assign w_next_prio = w_prio[gi+1];
            end

            assign w_used[gi]   = CW'(gi) < r_count;
            assign w_tail[gi]   = r_count == CW'(gi);
            assign w_rr_hot[gi] = w_rem_idx == AW'(gi);

            rqs_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_used      (w_used[gi]),
                .i_tail      (w_tail[gi]),
                .i_shift_en  (w_shift_en[gi]),
                .i_next_id   (w_next_id),
                .i_next_prio (w_next_prio),
                .o_id        (w_id[gi]),
                .o_prio      (w_prio[gi]),
                .o_flag      (w_flag[gi]),
                .o_zero      (w_zero[gi])
            );
        end

        // Read the selected slot's id through a one-hot AND-OR, one bit column at a time.
        for (gb = 0; gb < rqs_pkg::ID_W; gb++) begin : g_col
            for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_row
                assign w_id_col[gb][gi] = w_id[gi][gb];
            end
            assign w_chosen[gb] = |(w_id_col[gb] & r_sel);
        end
    endgenerate

    rqs_rr_mod #(
        .NUM_W (AW + 1),
        .DEN_W (CW)
    ) u_rr_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_num   ({1'b0, r_rr} + (AW + 1)'(1)),
        .i_den   (r_count),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    assign w_mod_start = w_accept && (i_req.data.req_type == rqs_pkg::REQ_SELECT)
                         && (r_count != '0) && (r_mode == rqs_pkg::MODE_RR);

    // Outcome of the request held in r_req, used in the apply state.
    always_comb begin
        w_status = rqs_pkg::ST_OK;
        w_load   = 1'b0;
        w_unload = 1'b0;
        w_valid  = 1'b0;
        n_count  = r_count;
        case (r_req.req_type)
            rqs_pkg::REQ_ADD: begin
                if (r_hit) begin
                    w_status = rqs_pkg::ST_DUPLICATE;
                end else if (!r_req.task_live) begin
                    w_status = rqs_pkg::ST_NOT_LIVE;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    w_status = rqs_pkg::ST_FULL;
                end else begin
                    w_load  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            rqs_pkg::REQ_REMOVE: begin
                if (r_hit) begin
                    w_unload = 1'b1;
                    n_count  = r_count - CW'(1);
                end else begin
                    w_status = rqs_pkg::ST_NOT_FOUND;
                end
            end
            rqs_pkg::REQ_SELECT: begin
                if (r_count == '0) begin
                    w_status = rqs_pkg::ST_EMPTY;
                end else begin
                    w_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Broadcast command to the chain.
    always_comb begin
        w_cmd.op       = rqs_pkg::CELL_HOLD;
        w_cmd.id       = r_req.task_id;
        w_cmd.prio     = r_req.task_prio;
        w_cmd.bit_sel  = r_bit;
        w_cmd.any_zero = w_any_zero;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.data.req_type == rqs_pkg::REQ_SELECT) begin
                        w_cmd.op = rqs_pkg::CELL_INIT;
                    end else begin
                        w_cmd.op = rqs_pkg::CELL_MATCH;
                        w_cmd.id = i_req.data.task_id;
                    end
                end
            end
            S_STEP: begin
                w_cmd.op = rqs_pkg::CELL_STEP;
            end
            S_APPLY: begin
                if (w_commit && w_load) begin
                    w_cmd.op = rqs_pkg::CELL_LOAD;
                end else if (w_commit && w_unload) begin
                    w_cmd.op = rqs_pkg::CELL_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= rqs_pkg::MODE_RESET;
            r_count     <= '0;
            r_rr        <= '0;
            r_bit       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.data;
            end

            // drop the result once taken; a commit below refills it
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req <= i_req.data;
                        if (i_req.data.req_type == rqs_pkg::REQ_SELECT) begin
                            if (r_count == '0) begin
                                r_sel   <= '0;
                                r_state <= S_APPLY;
                            end else begin
                                case (r_mode)
                                    rqs_pkg::MODE_FIFO: begin
                                        r_sel   <= QUEUE_DEPTH'(1);
                                        r_state <= S_APPLY;
                                    end
                                    rqs_pkg::MODE_RR: begin
                                        r_state <= S_MOD;
                                    end
                                    default: begin
                                        r_bit   <= rqs_pkg::BIT_W'(rqs_pkg::PRIO_W - 1);
                                        r_state <= S_STEP;
                                    end
                                endcase
                            end
                        end else if (i_req.data.req_type == rqs_pkg::REQ_ADD
                                     || i_req.data.req_type == rqs_pkg::REQ_REMOVE) begin
                            r_state <= S_FIND;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_STEP: begin
                    r_bit <= r_bit - rqs_pkg::BIT_W'(1);
                    if (r_bit == '0) begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_sel   <= w_first;
                    r_hit   <= w_any;
                    r_state <= S_APPLY;
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_sel   <= w_rr_hot;
                        r_rr    <= w_rem_idx;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    // hold until the output register is free
                    if (w_commit) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp.status       <= w_status;
            r_rsp.chosen_id    <= w_valid ? w_chosen : '0;
            r_rsp.chosen_valid <= w_valid;
            r_rsp.queue_count  <= rqs_pkg::CNT_OUT_W'(n_count);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    `RQS_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `RQS_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, w_commit && w_load, r_count == $past(r_count) + CW'(1))
    `RQS_ASSERT_SAME(a_remove_onehot, i_clk, i_rst_n, w_commit && w_unload, $onehot(r_sel))
    `RQS_ASSERT_SAME(a_chosen_ok, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.chosen_valid, o_rsp.data.status == rqs_pkg::ST_OK)

endmodule
